[rtl/core/nsv_pkg.sv]
`default_nettype none

package nsv_pkg;

  // token field width, fixed by the input format
  localparam int unsigned TOKEN_W = 16;

  // defaults for the top-level parameters
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned SIZE_BITS_DEF   = 15;

endpackage

`default_nettype wire

[rtl/core/nsv_ram.sv]
`default_nettype none

module nsv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/nested_size_validator.sv]
// nested_size_validator: checks a stream of signed tokens for correct nesting.
// input channel: token_i / last_token_i, accepted when token_valid_i is high and
//   token_stall_o is low. a negative token opens a level, a non-negative one closes
//   the innermost level and must match its size; inner sizes must sum below it.
// output channel: nested_ok_o, one beat per token marked last_token_i, taken when
//   result_valid_o is high and result_stall_i is low.
// throughput: one token per cycle while token_stall_o is low. the top of stack sits
//   in registers, the levels below it in a one-port-write, one-port-read ram; the
//   parent entry is prefetched and a push in the previous cycle is forwarded around
//   the ram. the verdict of a last token beat is registered in the output buffer.
// stall: a two-entry output buffer (output register plus skid) keeps tokens flowing
//   while a verdict waits; token_stall_o rises only when both entries are full.
// reset: no level open, no error pending, output buffer empty. the ram is never
//   cleared: only entries below the open-level count are read and each was written
//   when the level above it opened, so there is no clearing pass.
// after the first error the remaining tokens of the sequence are dropped until the
//   last one, which reports 0 and starts a fresh sequence.
`default_nettype none

module nested_size_validator #(
  parameter int unsigned STACK_DEPTH = nsv_pkg::STACK_DEPTH_DEF,
  parameter int unsigned SIZE_BITS   = nsv_pkg::SIZE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // token channel
  input  wire logic                               token_valid_i,
  output logic                                    token_stall_o,
  input  wire logic signed [nsv_pkg::TOKEN_W-1:0] token_i,
  input  wire logic                               last_token_i,
  // verdict channel
  output logic                                    result_valid_o,
  input  wire logic                               result_stall_i,
  output logic                                    nested_ok_o
);

  import nsv_pkg::*;

  localparam int unsigned SUM_BITS = SIZE_BITS + 1;
  localparam int unsigned ENTRY_W  = SIZE_BITS + SUM_BITS;
  // compare width: holds an opener magnitude (to 2^(TOKEN_W-1)) and any inner sum
  localparam int unsigned CW = (SUM_BITS > TOKEN_W + 1) ? SUM_BITS : TOKEN_W + 1;
  localparam int unsigned OW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  localparam logic [CW-1:0]       SIZE_MAX = CW'((64'd1 << SIZE_BITS) - 64'd1);
  localparam logic [SUM_BITS-1:0] SUM_MAX  = '1;
  localparam logic [OW-1:0]       DEPTH_OW = OW'(STACK_DEPTH);
  localparam logic [TOKEN_W:0]    NEG_BASE = (TOKEN_W + 1)'(1) << TOKEN_W;

  // stack control state
  logic [OW-1:0]       open_q, open_d;
  logic                failed_q, failed_d;
  // cached top of stack
  logic [SIZE_BITS-1:0] top_size_q, top_size_d;
  logic [SUM_BITS-1:0]  top_sum_q, top_sum_d;
  // forward path for a parent entry written in the cycle it was read
  logic                fwd_q, fwd_d;
  logic [ENTRY_W-1:0]  fwd_data_q, fwd_data_d;

  // ram ports
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [AW-1:0]       rd_addr;
  logic [ENTRY_W-1:0]  ram_rdata;

  // datapath
  logic                tok_acc;
  logic [OW-1:0]       open_m1;
  logic [OW-1:0]       open_d_m2;
  logic [TOKEN_W:0]    open_mag_raw;
  logic [CW-1:0]       open_mag;
  logic [CW-1:0]       close_mag;
  logic [ENTRY_W-1:0]  parent_entry;
  logic [SIZE_BITS-1:0] parent_size;
  logic [SUM_BITS-1:0]  parent_sum;
  logic [SUM_BITS:0]    sum_ext;
  logic [SUM_BITS-1:0]  sum_sat;
  logic                res_v;
  logic                res_ok;

  // output buffer
  logic                out_valid_q, out_valid_d;
  logic                out_ok_q, out_ok_d;
  logic                skid_valid_q, skid_valid_d;
  logic                skid_ok_q, skid_ok_d;
  logic                out_pop;

  assign tok_acc = token_valid_i && !token_stall_o;

  assign open_m1      = open_q - OW'(1);
  assign open_mag_raw = NEG_BASE - {1'b0, token_i};
  assign open_mag     = CW'(open_mag_raw);
  assign close_mag    = CW'(token_i[TOKEN_W-2:0]);

  // parent of the cached top: entry open_q-2, prefetched from the ram
  assign parent_entry = fwd_q ? fwd_data_q : ram_rdata;
  assign parent_size  = parent_entry[ENTRY_W-1 -: SIZE_BITS];
  assign parent_sum   = parent_entry[SUM_BITS-1:0];

  // closing size is added to the parent's inner sum, saturating
  assign sum_ext = {1'b0, parent_sum} + (SUM_BITS + 1)'(top_size_q);
  assign sum_sat = sum_ext[SUM_BITS] ? SUM_MAX : sum_ext[SUM_BITS-1:0];

  always_comb begin
    open_d     = open_q;
    failed_d   = failed_q;
    top_size_d = top_size_q;
    top_sum_d  = top_sum_q;
    wr_en      = 1'b0;
    res_v      = 1'b0;
    res_ok     = 1'b0;
    if (tok_acc) begin
      if (!failed_q) begin
        if (token_i[TOKEN_W-1]) begin
          // opener: too large to store or stack full is an error
          if (open_mag > SIZE_MAX || open_q == DEPTH_OW) begin
            failed_d = 1'b1;
          end else begin
            // spill the old top into the ram, new top starts with an empty sum
            wr_en      = (open_q != '0);
            top_size_d = open_mag[SIZE_BITS-1:0];
            top_sum_d  = '0;
            open_d     = open_q + OW'(1);
          end
        end else if (open_q == '0 || CW'(top_size_q) != close_mag ||
                     CW'(top_sum_q) >= close_mag) begin
          // nothing open, size mismatch or inner sizes too large
          failed_d = 1'b1;
        end else begin
          // pop: parent becomes the top with the closed size added
          open_d     = open_m1;
          top_size_d = parent_size;
          top_sum_d  = sum_sat;
        end
      end
      if (last_token_i) begin
        res_v    = 1'b1;
        res_ok   = !failed_d && (open_d == '0);
        open_d   = '0;
        failed_d = 1'b0;
      end
    end
  end

  assign wr_addr   = open_m1[AW-1:0];
  assign wr_data   = {top_size_q, top_sum_q};
  // prefetch the entry that becomes the parent for the next token
  assign open_d_m2 = open_d - OW'(2);
  assign rd_addr   = open_d_m2[AW-1:0];

  assign fwd_d      = wr_en && (wr_addr == rd_addr);
  assign fwd_data_d = wr_data;

  nsv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // output register plus skid entry
  assign out_pop = out_valid_q && !result_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_ok_d     = out_ok_q;
    skid_valid_d = skid_valid_q;
    skid_ok_d    = skid_ok_q;
    if (skid_valid_q) begin
      // input is stalled, so no new verdict arrives here
      if (out_pop) begin
        out_valid_d  = 1'b1;
        out_ok_d     = skid_ok_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_v) begin
      if (!out_valid_q || out_pop) begin
        out_valid_d = 1'b1;
        out_ok_d    = res_ok;
      end else begin
        skid_valid_d = 1'b1;
        skid_ok_d    = res_ok;
      end
    end else if (out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  assign token_stall_o  = skid_valid_q;
  assign result_valid_o = out_valid_q;
  assign nested_ok_o    = out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= '0;
      failed_q     <= 1'b0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      open_q       <= open_d;
      failed_q     <= failed_d;
      fwd_q        <= fwd_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_size_q <= top_size_d;
    top_sum_q  <= top_sum_d;
    fwd_data_q <= fwd_data_d;
    out_ok_q   <= out_ok_d;
    skid_ok_q  <= skid_ok_d;
  end

  // the open-level count never passes the stack depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= DEPTH_OW)
    else $error("open level count beyond stack depth");

  // a last token always leaves a fresh sequence behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_acc && last_token_i |=> open_q == '0 && !failed_q)
    else $error("sequence state not cleared after last token");

  // after an error, non-last tokens leave the stack alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_acc && failed_q && !last_token_i |=> $stable(open_q) && failed_q)
    else $error("token changed stack after error");

  // the skid entry only fills behind a held output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full with empty output register");

  // a push is written to the ram only below a nonempty top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> open_q != '0 && open_q != DEPTH_OW)
    else $error("ram write outside the stack");

endmodule

`default_nettype wire

[sim/nsv_verdict_checker.sv]
module nsv_verdict_checker (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       tok_valid_i,
  input  wire logic                                       tok_stall_i,
  input  wire logic signed [nsv_pkg::TOKEN_W-1:0]         token_i,
  input  wire logic                                       last_token_i,
  input  wire logic                                       res_valid_i,
  input  wire logic                                       res_stall_i,
  input  wire logic                                       nested_ok_i,
  output int                                              fail_count_o,
  output int                                              pending_o,
  output int                                              ok_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH    = nsv_pkg::STACK_DEPTH_DEF;
  localparam int unsigned SZ_BITS  = nsv_pkg::SIZE_BITS_DEF;
  localparam int          SIZE_TOP = (1 << SZ_BITS) - 1;
  localparam int          SUM_TOP  = (1 << (SZ_BITS + 1)) - 1;

  // shadow stack of open levels
  logic [SZ_BITS-1:0] lvl_size [DEPTH];
  logic [SZ_BITS:0]   lvl_sum  [DEPTH];
  int unsigned        open_cnt;
  bit                 seq_bad;

  bit   expected_verdicts [$];
  int   fail_total;
  int   ok_total;
  bit   want;

  function automatic void apply_token(input logic signed [nsv_pkg::TOKEN_W-1:0] tok);
    int value;
    int mag;
    int acc;
    int unsigned top;
    value = int'(tok);
    if (value < 0) begin
      mag = -value;
      if (mag > SIZE_TOP || open_cnt >= DEPTH) begin
        seq_bad = 1'b1;
        return;
      end
      lvl_size[open_cnt] = SZ_BITS'(mag);
      lvl_sum[open_cnt]  = '0;
      open_cnt++;
      return;
    end
    mag = value;
    if (open_cnt == 0) begin
      seq_bad = 1'b1;
      return;
    end
    top = open_cnt - 1;
    if (int'(lvl_size[top]) != mag || int'(lvl_sum[top]) >= mag) begin
      seq_bad = 1'b1;
      return;
    end
    open_cnt = top;
    if (open_cnt > 0) begin
      acc = int'(lvl_sum[top-1]) + mag;
      if (acc > SUM_TOP) acc = SUM_TOP;
      lvl_sum[top-1] = (SZ_BITS+1)'(acc);
    end
  endfunction

  task automatic flag(input string what);
    fail_total++;
    if (fail_total <= 10) $display("%s", what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_cnt = 0;
      seq_bad = 1'b0;
      expected_verdicts.delete();
      fail_total = 0;
      ok_total = 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          flag($sformatf("unexpected verdict beat: got %0b", nested_ok_i));
        end else begin
          want = expected_verdicts.pop_front();
          if (nested_ok_i !== want) begin
            flag($sformatf("verdict mismatch: expected %0b got %0b", want, nested_ok_i));
          end else if (want) begin
            ok_total++;
          end
        end
      end
      if (tok_valid_i && !tok_stall_i) begin
        if (!seq_bad) apply_token(token_i);
        if (last_token_i) begin
          expected_verdicts = {expected_verdicts, bit'(!seq_bad && open_cnt == 0)};
          open_cnt = 0;
          seq_bad = 1'b0;
        end
      end
    end
    fail_count_o <= fail_total;
    pending_o    <= expected_verdicts.size();
    ok_count_o   <= ok_total;
  end

endmodule

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_GOAL   = 1650;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SIZE    = (1 << nsv_pkg::SIZE_BITS_DEF) - 1;

  bit clk_i;
  logic rst_ni;

  // token channel, driven on the falling edge
  logic                                 tok_valid;
  logic                                 tok_stall;
  logic signed [nsv_pkg::TOKEN_W-1:0]   tok_data;
  logic                                 tok_last;

  // verdict channel
  logic res_valid;
  logic res_stall;
  logic res_ok;

  int  fail_count;
  int  pending;
  int  ok_count;

  int  tokens_sent;
  int  seq_count;
  int  cycles;
  bit  quiet;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  nested_size_validator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .token_valid_i  (tok_valid),
    .token_stall_o  (tok_stall),
    .token_i        (tok_data),
    .last_token_i   (tok_last),
    .result_valid_o (res_valid),
    .result_stall_i (res_stall),
    .nested_ok_o    (res_ok)
  );

  nsv_verdict_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_valid_i  (tok_valid),
    .tok_stall_i  (tok_stall),
    .token_i      (tok_data),
    .last_token_i (tok_last),
    .res_valid_i  (res_valid),
    .res_stall_i  (res_stall),
    .nested_ok_i  (res_ok),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .ok_count_o   (ok_count)
  );

  // roughly a third of the cycles idle, except inside the quiet window
  function automatic bit take_break();
    return !quiet && ($urandom_range(99) < 33);
  endfunction

  // receiver backpressure, changes only on the falling edge
  always @(negedge clk_i) begin
    res_stall <= take_break();
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // one token beat; entered and left just after a falling edge
  task automatic put_token(input int value, input bit is_last);
    quiet = (tokens_sent >= 700 && tokens_sent < 1000);
    while (take_break()) begin
      tok_valid <= 1'b0;
      @(negedge clk_i);
    end
    tok_valid <= 1'b1;
    tok_data  <= nsv_pkg::TOKEN_W'(value);
    tok_last  <= is_last;
    // stall is read before the edge updates land, so this sees the accepting edge
    @(posedge clk_i);
    while (tok_stall) @(posedge clk_i);
    tokens_sent++;
    if (is_last) seq_count++;
    @(negedge clk_i);
  endtask

  // occasionally swap in a fully random token, -32768 and zero included
  task automatic seq_token(input int value, input bit is_last);
    int v;
    v = value;
    if ($urandom_range(29) == 0) v = int'($urandom_range(65535)) - 32768;
    put_token(v, is_last);
  endtask

  function automatic int pick_size(input int room);
    if (room <= 1) return 1;
    if ($urandom_range(1)) return $urandom_range(1, room);
    return $urandom_range(1, (room < 8) ? room : 8);
  endfunction

  // mostly well-formed nesting with random sizes, sometimes cut short or overfilled
  task automatic gen_nested_seq();
    int  sz [$];
    int  sm [$];
    int  target;
    int  emitted;
    int  cut;
    int  room;
    int  child;
    int  s;
    bit  done;
    bit  fin;
    target  = $urandom_range(1, 24);
    emitted = 0;
    done    = 1'b0;
    cut     = ($urandom_range(15) == 0) ? $urandom_range(0, target - 1) : -1;
    while (!done) begin
      fin = (emitted == cut);
      if (sz.size() == 0) begin
        child = ($urandom_range(9) == 0) ? $urandom_range(1, MAX_SIZE)
                                         : $urandom_range(1, 300);
        sz = {sz, child};
        sm = {sm, 0};
        seq_token(-child, fin);
      end else begin
        room = sz[sz.size()-1] - sm[sm.size()-1] - 1;
        // now and then let the children fill the level exactly, which must fail
        if ($urandom_range(7) == 0) room++;
        if (room >= 1 && sz.size() < 70 && emitted < target && $urandom_range(1)) begin
          child = pick_size(room);
          sz = {sz, child};
          sm = {sm, 0};
          seq_token(-child, fin);
        end else begin
          s = sz.pop_back();
          void'(sm.pop_back());
          if (sz.size() > 0) sm[sm.size()-1] += s;
          if (sz.size() == 0 && emitted + 1 >= target) fin = 1'b1;
          seq_token(s, fin);
        end
      end
      emitted++;
      if (fin) done = 1'b1;
    end
  endtask

  // a straight chain of n levels; past the stack depth this overflows
  task automatic gen_deep(input int n);
    for (int i = 0; i < n; i++) put_token(-(n + 4 - i), 1'b0);
    for (int i = n - 1; i >= 0; i--) put_token(n + 4 - i, i == 0);
  endtask

  task automatic gen_noise();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) put_token(int'($urandom_range(65535)) - 32768, i == len - 1);
  endtask

  initial begin
    int pick;
    tok_valid = 1'b0;
    tok_data  = '0;
    tok_last  = 1'b0;
    res_stall = 1'b0;
    rst_ni    = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero token closes nothing valid
    put_token(0, 1'b1);
    // close with nothing open
    put_token(5, 1'b1);
    // smallest level, empty inside
    put_token(-1, 1'b0);
    put_token(1, 1'b1);
    // largest storable sizes, inner sum one below the outer size
    put_token(-MAX_SIZE, 1'b0);
    put_token(-(MAX_SIZE - 1), 1'b0);
    put_token(MAX_SIZE - 1, 1'b0);
    put_token(MAX_SIZE, 1'b1);
    // most negative token does not fit a level
    put_token(-32768, 1'b1);
    // size mismatch, then the rest is ignored up to the last beat
    put_token(-3, 1'b0);
    put_token(4, 1'b0);
    put_token(-7, 1'b0);
    put_token(3, 1'b1);
    // children summing exactly to the parent size
    put_token(-2, 1'b0);
    put_token(-1, 1'b0);
    put_token(1, 1'b0);
    put_token(-1, 1'b0);
    put_token(1, 1'b0);
    put_token(2, 1'b1);
    // inner sum runs into saturation
    put_token(-MAX_SIZE, 1'b0);
    put_token(-MAX_SIZE, 1'b0);
    put_token(MAX_SIZE, 1'b0);
    put_token(-MAX_SIZE, 1'b0);
    put_token(MAX_SIZE, 1'b0);
    put_token(-MAX_SIZE, 1'b0);
    put_token(MAX_SIZE, 1'b0);
    put_token(MAX_SIZE, 1'b1);
    // opener marked last leaves a level open
    put_token(-5, 1'b1);

    // full stack, then one level too many
    gen_deep(nsv_pkg::STACK_DEPTH_DEF);
    gen_deep(nsv_pkg::STACK_DEPTH_DEF + 1);

    while (tokens_sent < ITEM_GOAL) begin
      pick = $urandom_range(99);
      if (pick < 84) gen_nested_seq();
      else if (pick < 97) gen_noise();
      else gen_deep($urandom_range(nsv_pkg::STACK_DEPTH_DEF - 3, nsv_pkg::STACK_DEPTH_DEF + 2));
    end
    tok_valid <= 1'b0;

    // drain outstanding verdicts, then wait for stray beats
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("covered %0d tokens in %0d sequences, %0d judged well nested",
             tokens_sent, seq_count, ok_count);
    $display("directed corners, full and overflowing stacks, random nesting and noise");
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
